@@ src/morse_pkg.sv @@
`timescale 1ns / 1ps

package morse_pkg;

  localparam int unsigned MaxSyms  = 5;
  localparam int unsigned NumChars = 36;
  localparam int unsigned NumAlpha = 26;

  localparam logic [7:0] SymDot    = 8'h2E;
  localparam logic [7:0] SymDash   = 8'h2D;
  localparam logic [7:0] SymSep    = 8'h7C;
  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharZ     = 8'h5A;
  localparam logic [7:0] Char0     = 8'h30;
  localparam logic [7:0] Char9     = 8'h39;

  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  // bits[k] is set when symbol k is a dash
  typedef struct packed {
    logic [2:0] len;
    logic [4:0] bits;
  } code_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] chr;
  } dec_res_t;

  // entries 0..25 are A..Z, 26..35 are 0..9
  function automatic code_t itu_code(input logic [5:0] idx);
    code_t c;
    case (idx)
      6'd0:  c = '{3'd2, 5'b00010};
      6'd1:  c = '{3'd4, 5'b00001};
      6'd2:  c = '{3'd4, 5'b00101};
      6'd3:  c = '{3'd3, 5'b00001};
      6'd4:  c = '{3'd1, 5'b00000};
      6'd5:  c = '{3'd4, 5'b00100};
      6'd6:  c = '{3'd3, 5'b00011};
      6'd7:  c = '{3'd4, 5'b00000};
      6'd8:  c = '{3'd2, 5'b00000};
      6'd9:  c = '{3'd4, 5'b01110};
      6'd10: c = '{3'd3, 5'b00101};
      6'd11: c = '{3'd4, 5'b00010};
      6'd12: c = '{3'd2, 5'b00011};
      6'd13: c = '{3'd2, 5'b00001};
      6'd14: c = '{3'd3, 5'b00111};
      6'd15: c = '{3'd4, 5'b00110};
      6'd16: c = '{3'd4, 5'b01011};
      6'd17: c = '{3'd3, 5'b00010};
      6'd18: c = '{3'd3, 5'b00000};
      6'd19: c = '{3'd1, 5'b00001};
      6'd20: c = '{3'd3, 5'b00100};
      6'd21: c = '{3'd4, 5'b01000};
      6'd22: c = '{3'd3, 5'b00110};
      6'd23: c = '{3'd4, 5'b01001};
      6'd24: c = '{3'd4, 5'b01101};
      6'd25: c = '{3'd4, 5'b00011};
      6'd26: c = '{3'd5, 5'b11111};
      6'd27: c = '{3'd5, 5'b11110};
      6'd28: c = '{3'd5, 5'b11100};
      6'd29: c = '{3'd5, 5'b11000};
      6'd30: c = '{3'd5, 5'b10000};
      6'd31: c = '{3'd5, 5'b00000};
      6'd32: c = '{3'd5, 5'b00001};
      6'd33: c = '{3'd5, 5'b00011};
      6'd34: c = '{3'd5, 5'b00111};
      6'd35: c = '{3'd5, 5'b01111};
      default: c = '{3'd0, 5'b00000};
    endcase
    return c;
  endfunction

  function automatic logic [7:0] entry_char(input logic [5:0] idx);
    logic [7:0] wide;
    wide = {2'b00, idx};
    return (wide < 8'(NumAlpha)) ? (CharA + wide) : (Char0 + wide - 8'(NumAlpha));
  endfunction

endpackage

@@ src/morse_codec.sv @@
`timescale 1ns / 1ps

// Morse encoder / decoder on a byte stream.
// s_axis carries one input byte per beat; m_axis returns result beats with
// tlast marking the final beat caused by that input byte. cfg_* writes the
// direction bit (0 encode, 1 decode); write it only while the block is idle.
// Encode: A-Z and 0-9 give one '.' or '-' beat per symbol and then a '|'
// beat with tlast set; any other byte gives no beat.
// Decode: '.' and '-' gather a code of up to five symbols, '|' gives the
// matching character as one beat with tlast set, or nothing.
// An input byte is registered as a job in the emit stage; its result beats
// (1 to 6) load one per cycle into the output register while m_axis_tready
// allows, and the next byte is taken as the last of them loads. Bytes with
// one result or none are taken every cycle while m_axis_tready is high.
// Reset clears the direction to encode and empties the decode code.
// When m_axis_tready is low the output beat holds; once a job waits behind
// it, s_axis_tready stays low until that job has loaded its last beat.
module morse_codec
  import morse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  logic       dir_q;

  logic       job_valid_q, job_valid_d;
  logic [2:0] job_len_q, job_len_d;
  logic [2:0] job_pos_q, job_pos_d;
  logic [4:0] job_bits_q, job_bits_d;
  logic [7:0] job_final_q, job_final_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;

  logic       out_load, job_at_final, in_fire;
  logic       enc_hit, new_hit;
  logic [5:0] enc_idx;
  code_t      enc_code;
  dec_res_t   dec_res;

  assign cfg_ready_o = 1'b1;

  morse_dec u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_fire && dir_q == DirDecode),
    .byte_i (s_axis_tdata),
    .res_o  (dec_res)
  );

  always_comb begin
    enc_hit = 1'b0;
    enc_idx = '0;
    if (s_axis_tdata inside {[CharA:CharZ]}) begin
      enc_hit = 1'b1;
      enc_idx = 6'(s_axis_tdata - CharA);
    end else if (s_axis_tdata inside {[Char0:Char9]}) begin
      enc_hit = 1'b1;
      enc_idx = 6'(s_axis_tdata - Char0 + 8'(NumAlpha));
    end
    enc_code = itu_code(enc_idx);
  end

  always_comb begin
    out_load      = job_valid_q && (!out_valid_q || m_axis_tready);
    job_at_final  = job_pos_q == job_len_q;
    s_axis_tready = !job_valid_q || (out_load && job_at_final);
    in_fire       = s_axis_tvalid && s_axis_tready;
    new_hit       = (dir_q == DirDecode) ? dec_res.hit : enc_hit;

    job_valid_d = job_valid_q;
    job_len_d   = job_len_q;
    job_pos_d   = job_pos_q;
    job_bits_d  = job_bits_q;
    job_final_d = job_final_q;
    if (out_load) begin
      if (job_at_final) begin
        job_valid_d = 1'b0;
      end else begin
        job_pos_d = job_pos_q + 3'd1;
      end
    end
    if (in_fire && new_hit) begin
      job_valid_d = 1'b1;
      job_pos_d   = '0;
      if (dir_q == DirDecode) begin
        job_len_d   = '0;
        job_bits_d  = '0;
        job_final_d = dec_res.chr;
      end else begin
        job_len_d   = enc_code.len;
        job_bits_d  = enc_code.bits;
        job_final_d = SymSep;
      end
    end

    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_last_d  = job_at_final;
      if (job_at_final) begin
        out_byte_d = job_final_q;
      end else begin
        out_byte_d = job_bits_q[job_pos_q] ? SymDash : SymDot;
      end
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q       <= DirEncode;
      job_valid_q <= 1'b0;
      job_pos_q   <= '0;
      job_len_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        dir_q <= cfg_data_i;
      end
      job_valid_q <= job_valid_d;
      job_pos_q   <= job_pos_d;
      job_len_q   <= job_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_bits_q  <= job_bits_d;
    job_final_q <= job_final_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> job_pos_q <= job_len_q)
    else $error("emit position past the end of the job");

  a_ready_only_when_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && job_valid_q |-> out_load && job_at_final)
    else $error("input taken while a job still has beats to send");

  a_mid_beats_are_symbols: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_last_q |-> out_byte_q == SymDot || out_byte_q == SymDash)
    else $error("non-final beat is not a dot or dash");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q)
    else $error("output register lost a loaded beat");

endmodule

@@ src/morse_dec.sv @@
`timescale 1ns / 1ps

module morse_dec
  import morse_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  logic [7:0] byte_i,
  output dec_res_t res_o
);

  logic [4:0] code_bits_q, code_bits_d;
  logic [2:0] code_len_q, code_len_d;
  logic       code_invalid_q, code_invalid_d;

  // match the gathered code against the table
  always_comb begin
    code_t c;
    res_o = '0;
    for (int i = 0; i < NumChars; i++) begin
      c = itu_code(6'(i));
      if (!res_o.hit && c.len == code_len_q && c.bits == code_bits_q) begin
        res_o.hit = 1'b1;
        res_o.chr = entry_char(6'(i));
      end
    end
    if (byte_i != SymSep || code_len_q == 3'd0 || code_invalid_q) begin
      res_o.hit = 1'b0;
    end
  end

  always_comb begin
    code_bits_d    = code_bits_q;
    code_len_d     = code_len_q;
    code_invalid_d = code_invalid_q;
    if (step_i) begin
      if (byte_i == SymDot || byte_i == SymDash) begin
        if (code_len_q >= 3'(MaxSyms)) begin
          code_invalid_d = 1'b1;
        end else begin
          if (byte_i == SymDash) begin
            code_bits_d[code_len_q] = 1'b1;
          end
          code_len_d = code_len_q + 3'd1;
        end
      end else if (byte_i == SymSep) begin
        code_bits_d    = '0;
        code_len_d     = '0;
        code_invalid_d = 1'b0;
      end else begin
        code_invalid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bits_q    <= '0;
      code_len_q     <= '0;
      code_invalid_q <= 1'b0;
    end else begin
      code_bits_q    <= code_bits_d;
      code_len_q     <= code_len_d;
      code_invalid_q <= code_invalid_d;
    end
  end

  a_len_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_len_q <= 3'(MaxSyms))
    else $error("symbol count beyond five");

  a_sep_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && byte_i == SymSep |=> code_len_q == 3'd0 && !code_invalid_q && code_bits_q == 5'd0)
    else $error("separator did not clear the code");

  a_bits_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (code_bits_q >> code_len_q) == 5'd0)
    else $error("dash bit set beyond the gathered length");

endmodule

@@ verif/morse_codec_checker.sv @@
`timescale 1ns / 1ps

module morse_codec_checker
  import morse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [7:0] sym;
    logic       last;
  } beat_t;

  beat_t      expected_beats[$];
  beat_t      oldest_beat;

  logic       direction_q;
  logic [4:0] dash_mask_q;
  logic [2:0] sym_count_q;
  logic       code_bad_q;

  // ITU symbols: 0..25 are A..Z, 26..35 are 0..9
  function automatic string itu_symbols(input int unsigned idx);
    case (idx)
      0:  return ".-";
      1:  return "-...";
      2:  return "-.-.";
      3:  return "-..";
      4:  return ".";
      5:  return "..-.";
      6:  return "--.";
      7:  return "....";
      8:  return "..";
      9:  return ".---";
      10: return "-.-";
      11: return ".-..";
      12: return "--";
      13: return "-.";
      14: return "---";
      15: return ".--.";
      16: return "--.-";
      17: return ".-.";
      18: return "...";
      19: return "-";
      20: return "..-";
      21: return "...-";
      22: return ".--";
      23: return "-..-";
      24: return "-.--";
      25: return "--..";
      26: return "-----";
      27: return ".----";
      28: return "..---";
      29: return "...--";
      30: return "....-";
      31: return ".....";
      32: return "-....";
      33: return "--...";
      34: return "---..";
      35: return "----.";
      default: return "";
    endcase
  endfunction

  task automatic predict_beats(input logic [7:0] b);
    string       code;
    int unsigned idx;
    int unsigned k;
    logic [4:0]  mask;
    logic        found;
    if (direction_q == DirEncode) begin
      idx = NumChars;
      if (b >= CharA && b <= CharZ) begin
        idx = b - CharA;
      end else if (b >= Char0 && b <= Char9) begin
        idx = NumAlpha + (b - Char0);
      end
      if (idx < NumChars) begin
        code = itu_symbols(idx);
        for (k = 0; k < code.len(); k++) begin
          expected_beats.push_back('{code[k], 1'b0});
        end
        expected_beats.push_back('{SymSep, 1'b1});
      end
    end else if (b == SymDot || b == SymDash) begin
      // a sixth symbol spoils the code but is not stored
      if (sym_count_q == 3'(MaxSyms)) begin
        code_bad_q = 1'b1;
      end else begin
        if (b == SymDash) begin
          dash_mask_q[sym_count_q] = 1'b1;
        end
        sym_count_q = sym_count_q + 3'd1;
      end
    end else if (b != SymSep) begin
      code_bad_q = 1'b1;
    end else begin
      if (sym_count_q != 3'd0 && !code_bad_q) begin
        found = 1'b0;
        for (idx = 0; idx < NumChars && !found; idx++) begin
          code = itu_symbols(idx);
          mask = '0;
          for (k = 0; k < code.len(); k++) begin
            if (code[k] == SymDash) begin
              mask[k] = 1'b1;
            end
          end
          if (code.len() == sym_count_q && mask == dash_mask_q) begin
            found = 1'b1;
            if (idx < NumAlpha) begin
              expected_beats.push_back('{CharA + 8'(idx), 1'b1});
            end else begin
              expected_beats.push_back('{Char0 + 8'(idx - NumAlpha), 1'b1});
            end
          end
        end
      end
      dash_mask_q = '0;
      sym_count_q = '0;
      code_bad_q  = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_beats.delete();
      direction_q  = DirEncode;
      dash_mask_q  = '0;
      sym_count_q  = '0;
      code_bad_q   = 1'b0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // the beat at this edge still sees the old direction
      if (s_axis_tvalid && s_axis_tready) begin
        predict_beats(s_axis_tdata);
      end
      if (cfg_valid_i && cfg_ready_i) begin
        direction_q = cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat, got data %h last %b",
                   $time, m_axis_tdata, m_axis_tlast);
          fail_count_o++;
        end else begin
          oldest_beat = expected_beats.pop_front();
          if (m_axis_tdata !== oldest_beat.sym || m_axis_tlast !== oldest_beat.last) begin
            $display("%0t: beat mismatch, expected data %h last %b, got data %h last %b",
                     $time, oldest_beat.sym, oldest_beat.last, m_axis_tdata, m_axis_tlast);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_beats.size();
    end
  end

endmodule

@@ verif/morse_codec_tb.sv @@
`timescale 1ns / 1ps

module morse_codec_tb
  import morse_pkg::*;
;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ItemTarget = 195;
  localparam int unsigned HoldCycles = 300;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_data_i;

  int unsigned mismatch_count;
  int unsigned beats_outstanding;
  int unsigned cycle_count = 0;
  int unsigned items_sent;
  int unsigned burst_left;
  logic        hold_req;

  morse_codec u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  morse_codec_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (mismatch_count),
    .pending_o     (beats_outstanding)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: ready pattern steps through four modes, plus one long hold-off
  initial begin : receiver
    int unsigned stall;
    int unsigned span;
    logic        held;
    logic        rdy;
    m_axis_tready = 1'b0;
    stall = 0;
    span  = 0;
    held  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      span++;
      if (hold_req && !held) begin
        held  = 1'b1;
        stall = HoldCycles;
      end
      if (stall != 0) begin
        stall--;
        rdy = 1'b0;
      end else begin
        case ((span / 80) % 4)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 3) != 0);
          2: rdy = ($urandom_range(0, 3) == 0);
          default: begin
            if ($urandom_range(0, 9) == 0) begin
              stall = $urandom_range(2, 15);
            end
            rdy = (stall == 0);
          end
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  // offer one byte; open a new burst after a random gap when the old one runs out
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    int unsigned k;
    for (k = 0; k < s.len(); k++) begin
      send_byte(s[k]);
    end
  endtask

  task automatic send_random_symbols(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      send_byte($urandom_range(0, 1) ? SymDash : SymDot);
    end
  endtask

  // drain, let the last ignored bytes clear the pipe, then write direction
  task automatic set_direction(input logic dir);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (beats_outstanding != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= dir;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic encode_phase(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 35) < NumAlpha) begin
          send_byte(CharA + 8'($urandom_range(0, NumAlpha - 1)));
        end else begin
          send_byte(Char0 + 8'($urandom_range(0, 9)));
        end
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic decode_phase(input int unsigned n);
    int unsigned start;
    int unsigned pick;
    start = items_sent;
    while (items_sent - start < n) begin
      pick = $urandom_range(0, 19);
      if (pick < 13) begin
        send_random_symbols($urandom_range(1, 4));
        send_byte(SymSep);
      end else if (pick < 16) begin
        send_random_symbols(MaxSyms);
        send_byte(SymSep);
      end else if (pick < 18) begin
        // too long
        send_random_symbols($urandom_range(MaxSyms + 1, MaxSyms + 2));
        send_byte(SymSep);
      end else if (pick < 19) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(SymSep);
      end
    end
    // leave a partial code to carry across the direction change
    if ($urandom_range(0, 1) != 0) begin
      send_random_symbols($urandom_range(1, 3));
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = DirEncode;
    hold_req      = 1'b0;
    items_sent    = 0;
    burst_left    = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_direction(DirEncode);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("AZ09");

    set_direction(DirDecode);
    send_text(".-|");
    send_text("......|");
    send_text("|");
    send_byte(SymDash);
    send_byte(8'hFF);
    send_byte(SymSep);
    send_text("..--|");
    // partial code survives an encode phase
    send_text("-.");

    set_direction(DirEncode);
    hold_req = 1'b1;
    encode_phase($urandom_range(20, 40));
    while (items_sent < ItemTarget) begin
      set_direction(DirDecode);
      decode_phase($urandom_range(20, 40));
      if (items_sent < ItemTarget) begin
        set_direction(DirEncode);
        encode_phase($urandom_range(15, 35));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (beats_outstanding != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/morse_pkg.sv
src/morse_dec.sv
src/morse_codec.sv
verif/morse_codec_checker.sv
verif/morse_codec_tb.sv
